[design/unsigned_to_text_radix_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef UNSIGNED_TO_TEXT_RADIX_TOP_DEFINES_SVH
`define UNSIGNED_TO_TEXT_RADIX_TOP_DEFINES_SVH

// Checked at every edge once reset is released.
`define URT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define URT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/urt_pkg.sv]
package urt_pkg;

  localparam int VALUE_WIDTH   = 64;
  localparam int IN_WIDTH      = 64;
  localparam int BITS_PER_STEP = 8;
  localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W         = STEPS * BITS_PER_STEP;
  localparam int STEP_IDX_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DIGIT_AW      = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int RADIX_W       = 5;
  localparam int REM_W         = 4;
  localparam int CHAR_W        = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A_MINUS = 7'd87;  // 'a' minus ten
  localparam logic [REM_W-1:0]  DEC_LIMIT    = 4'd10;

  // One converted value waiting for the divider.
  typedef struct packed {
    logic [PAD_W-1:0]      value;
    logic [STEP_IDX_W-1:0] top;    // index of the highest nonzero byte
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] v);
    logic [RADIX_W-1:0] r;
    r = v;
    if (v < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (v > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A_MINUS + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

[design/unsigned_to_text_radix_top.sv]
// Flow: each value passes through the job queue; then, per digit, the byte-wide divider works
// one byte at a time from the leading nonzero byte of the remaining quotient down to byte zero.
// The digits are then read from the digit store into a read register and on into the result
// queue. The back end takes a new value only once it has issued the reads for every digit
// of the previous one; the front-end queue keeps accepting values meanwhile.
// Reset: asynchronous, active low; clears all queues and sets the base to 16.
module unsigned_to_text_radix_top import urt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                radix_we_i,
  input  logic [RADIX_W-1:0]  radix_i,
  input  logic                push,
  output logic                full,
  input  logic [IN_WIDTH-1:0] value_i,
  output logic                empty,
  input  logic                pop,
  output logic [CHAR_W-1:0]   digit_char_o,
  output logic                last_digit_o
);

  // The base register. Writes outside the meaningful range are clamped to the
  // nearest legal base, so the divider never sees a base of zero or one.
  logic [RADIX_W-1:0] radix_q, radix_d;

  // Handoff from the front end to the divider.
  logic job_valid;
  logic job_ready;
  job_t job;

  assign radix_d = radix_we_i ? clamp_radix(radix_i) : radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  // The front end takes each input transaction, masks it to the value width,
  // records its leading nonzero byte and parks it in a two-entry queue. It
  // keeps accepting while the back end is still busy with an earlier value.
  urt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // The back end divides repeatedly by the base, storing remainders least
  // significant first, then reads them back most significant first into a
  // two-entry result queue. Each result transaction carries one character;
  // the last character of a value is flagged.
  urt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_q),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_ready_o  (job_ready),
    .empty_o      (empty),
    .pop_i        (pop),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

[design/urt_front.sv]
module urt_front import urt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [IN_WIDTH-1:0] value_i,
  output logic                job_valid_o,
  output job_t                job_o,
  input  logic                job_ready_i
);

  job_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  job_t       new_job;
  logic       do_push, do_pop;

  // Mask to the configured width and find the leading nonzero byte, so the
  // divider skips bytes that are known to be zero.
  always_comb begin
    new_job.value = PAD_W'(value_i[VALUE_WIDTH-1:0]);
    new_job.top   = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (new_job.value[i*BITS_PER_STEP +: BITS_PER_STEP] != '0) begin
        new_job.top = STEP_IDX_W'(i);
      end
    end
  end

  assign full        = (count_q == 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign job_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= new_job;
    end
  end

endmodule

[design/urt_back.sv]
module urt_back import urt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RADIX_W-1:0] radix_i,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_ready_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               last_digit_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } result_t;

  back_state_e           state_q, state_d;
  logic [PAD_W-1:0]      n_q, n_d;
  logic [STEP_IDX_W-1:0] top_q, top_d;
  logic [STEP_IDX_W-1:0] byte_q, byte_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [DIGIT_AW-1:0]   wr_q, wr_d;
  logic [DIGIT_AW-1:0]   rd_q, rd_d;
  logic                  infl_q, infl_d;
  logic                  infl_last_q, infl_last_d;
  logic [REM_W-1:0]      rd_data_q;
  logic [REM_W-1:0]      digit_mem [VALUE_WIDTH];

  result_t    oq_q [2];
  logic       oq_wr_q, oq_rd_q;
  logic [1:0] oq_cnt_q, oq_cnt_d;

  logic [BITS_PER_STEP-1:0] dbyte, qbyte;
  logic [REM_W-1:0]         rem_new;
  logic [RADIX_W-1:0]       part;
  logic [PAD_W-1:0]         n_div;
  logic [STEP_IDX_W-1:0]    top_next;
  logic                     mem_we, rd_en, oq_push, oq_pop;

  // One byte of long division per cycle, one quotient bit per step.
  always_comb begin
    dbyte   = n_q[byte_q*BITS_PER_STEP +: BITS_PER_STEP];
    rem_new = rem_q;
    qbyte   = '0;
    part    = '0;
    for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
      part = {rem_new, dbyte[b]};
      if (part >= radix_i) begin
        part     = part - radix_i;
        qbyte[b] = 1'b1;
      end
      rem_new = part[REM_W-1:0];
    end
    n_div = n_q;
    n_div[byte_q*BITS_PER_STEP +: BITS_PER_STEP] = qbyte;
  end

  // A divide by at most sixteen drops the leading byte by one at most.
  always_comb begin
    top_next = top_q;
    if (top_q != '0 && n_q[top_q*BITS_PER_STEP +: BITS_PER_STEP] == '0) begin
      top_next = top_q - 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    top_d       = top_q;
    byte_d      = byte_q;
    rem_d       = rem_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    infl_d      = 1'b0;
    infl_last_d = infl_last_q;
    job_ready_o = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_ready_o = 1'b1;
          n_d         = job_i.value;
          top_d       = job_i.top;
          byte_d      = job_i.top;
          rem_d       = '0;
          wr_d        = '0;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        n_d = n_div;
        if (byte_q == '0) begin
          mem_we = 1'b1;
          rem_d  = '0;
          wr_d   = wr_q + 1'b1;
          top_d  = top_next;
          byte_d = top_next;
          if (n_div == '0) begin
            rd_d    = wr_q;
            state_d = ST_EMIT;
          end
        end else begin
          rem_d  = rem_new;
          byte_d = byte_q - 1'b1;
        end
      end
      ST_EMIT: begin
        // Issue a read only when the result queue has room for its data.
        if ((oq_cnt_q + {1'b0, infl_q}) < 2'd2) begin
          rd_en       = 1'b1;
          infl_d      = 1'b1;
          infl_last_d = (rd_q == '0);
          if (rd_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_d = rd_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign oq_push      = infl_q;
  assign empty_o      = (oq_cnt_q == 2'd0);
  assign oq_pop       = pop_i && !empty_o;
  assign digit_char_o = oq_q[oq_rd_q].ch;
  assign last_digit_o = oq_q[oq_rd_q].last;
  assign oq_cnt_d     = oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      infl_q   <= 1'b0;
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      infl_q   <= infl_d;
      oq_wr_q  <= oq_wr_q ^ oq_push;
      oq_rd_q  <= oq_rd_q ^ oq_pop;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    top_q       <= top_d;
    byte_q      <= byte_d;
    rem_q       <= rem_d;
    wr_q        <= wr_d;
    rd_q        <= rd_d;
    infl_last_q <= infl_last_d;
    if (oq_push) begin
      oq_q[oq_wr_q] <= '{ch: digit_to_char(rd_data_q), last: infl_last_q};
    end
  end

  // Digit store: written least significant first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[wr_q] <= rem_new;
    end
    if (rd_en) begin
      rd_data_q <= digit_mem[rd_q];
    end
  end

endmodule

[design/urt_checker.sv]
`include "unsigned_to_text_radix_top_defines.svh"

module urt_checker import urt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [CHAR_W-1:0] digit_char_o,
  input logic              last_digit_o
);

  // Set while the next result is the first digit of a value.
  logic first_q, first_d;

  assign first_d = (pop && !empty) ? last_digit_o : first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

  `URT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (empty && !full), "not idle in reset")
  `URT_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(digit_char_o) && $stable(last_digit_o)), "result changed while waiting")
  `URT_ASSERT(a_ascii, !empty |-> ((digit_char_o >= 7'd48 && digit_char_o <= 7'd57) || (digit_char_o >= 7'd97 && digit_char_o <= 7'd102)), "bad digit character")
  `URT_ASSERT(a_no_lead_zero, (!empty && first_q && digit_char_o == 7'd48) |-> last_digit_o, "leading zero digit")

endmodule

bind unsigned_to_text_radix_top urt_checker u_checker (.*);

[bench/unsigned_to_text_radix_digit_checker.sv]
module unsigned_to_text_radix_digit_checker import urt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                radix_we_i,
  input  logic [RADIX_W-1:0]  radix_i,
  input  logic                push,
  input  logic                full,
  input  logic [IN_WIDTH-1:0] value_i,
  input  logic                empty,
  input  logic                pop,
  input  logic [CHAR_W-1:0]   digit_char_o,
  input  logic                last_digit_o,
  output int                  pending_o,
  output int                  mismatches_o
);

  localparam logic [RADIX_W-1:0] BASE_LOW         = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_HIGH        = 5'd16;
  localparam logic [RADIX_W-1:0] BASE_AFTER_RESET = 5'd16;
  localparam logic [7:0]         ASCII_ZERO       = 8'h30;
  localparam logic [7:0]         ASCII_LOWER_A    = 8'h61;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              is_last;
  } digit_due_t;

  logic [RADIX_W-1:0] base_q;
  digit_due_t         digits_due [$];
  int                 due_count = 0;
  int                 mismatch_total = 0;

  assign pending_o    = due_count;
  assign mismatches_o = mismatch_total;

  function automatic logic [RADIX_W-1:0] limit_base(logic [RADIX_W-1:0] written);
    logic [RADIX_W-1:0] b;
    b = written;
    if (b < BASE_LOW) begin
      b = BASE_LOW;
    end
    if (b > BASE_HIGH) begin
      b = BASE_HIGH;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph_of(logic [3:0] d);
    logic [7:0] code;
    if (d <= 4'd9) begin
      code = ASCII_ZERO + 8'(d);
    end else begin
      code = ASCII_LOWER_A + 8'(d - 4'd10);
    end
    return code[CHAR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t digit mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  // Queue the digits of one accepted value, most significant first.
  task automatic spell_value(input logic [IN_WIDTH-1:0] raw);
    logic [63:0] n;
    logic [63:0] b;
    logic [3:0]  low_first [$];
    digit_due_t  e;
    n = 64'(raw);
    if (VALUE_WIDTH < 64) begin
      n = n & ((64'd1 << VALUE_WIDTH) - 64'd1);
    end
    b = 64'(base_q);
    do begin
      low_first.push_back(4'(n % b));
      n = n / b;
    end while (n != 0);
    for (int k = low_first.size() - 1; k >= 0; k--) begin
      e.glyph   = glyph_of(low_first[k]);
      e.is_last = (k == 0);
      digits_due.push_back(e);
    end
  endtask

  task automatic check_digit();
    digit_due_t e;
    if (digits_due.size() == 0) begin
      report_mismatch($sformatf("unexpected digit 0x%0h last=%0b", digit_char_o, last_digit_o));
    end else begin
      e = digits_due.pop_front();
      if (digit_char_o !== e.glyph) begin
        report_mismatch($sformatf("char 0x%0h, expected 0x%0h", digit_char_o, e.glyph));
      end
      if (last_digit_o !== e.is_last) begin
        report_mismatch($sformatf("last flag %0b, expected %0b", last_digit_o, e.is_last));
      end
    end
  endtask

  // Register writes and conversions never overlap, so the base seen by a
  // push is always the one left by the last completed write.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_AFTER_RESET;
      digits_due.delete();
    end else begin
      if (radix_we_i) begin
        base_q <= limit_base(radix_i);
      end
      if (push && !full) begin
        spell_value(value_i);
      end
      if (pop && !empty) begin
        check_digit();
      end
    end
    due_count = digits_due.size();
  end

endmodule

[bench/unsigned_to_text_radix_top_test.sv]
module unsigned_to_text_radix_top_test;
  import urt_pkg::*;

  // Time limit for the whole run; the watchdog below ends the test here.
  localparam longint RUN_LIMIT      = 64'd24_000_000;
  localparam int     RANDOM_PHASES  = 10;
  localparam int     PHASE_ITEMS    = 43;
  localparam int     LONG_HOLD      = 1200;
  // Extra reading time after the last expected digit has arrived.
  localparam int     DRAIN_CYCLES   = 400;
  localparam int     SETTLE_CYCLES  = 4;

  logic                clk_i;
  logic                rst_ni;
  logic                radix_we_i;
  logic [RADIX_W-1:0]  radix_i;
  logic                push;
  logic                full;
  logic [IN_WIDTH-1:0] value_i;
  logic                empty;
  logic                pop;
  logic [CHAR_W-1:0]   digit_char_o;
  logic                last_digit_o;

  int pending;
  int mismatches;

  // Shared between the sender and the receiver. When no_gaps is set neither
  // side idles, which gives back-to-back stretches. hold_output asks the
  // receiver for one long stall so that the block backs up to its input.
  bit no_gaps     = 1'b0;
  bit hold_output = 1'b0;
  bit hold_served = 1'b0;

  unsigned_to_text_radix_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_we_i   (radix_we_i),
    .radix_i      (radix_i),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  unsigned_to_text_radix_digit_checker digit_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_we_i   (radix_we_i),
    .radix_i      (radix_i),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Random values are shaped by bit length so that every digit count shows
  // up in every base, with some tiny values and some edge patterns mixed in.
  function automatic logic [IN_WIDTH-1:0] draw_value();
    logic [63:0] raw;
    int          kind;
    int          span;
    raw  = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    span = $urandom_range(1, 64);
    if (kind < 6) begin
      raw = raw >> (64 - span);
    end else if (kind < 8) begin
      raw = 64'($urandom_range(0, 40));
    end else if (kind == 9) begin
      case ($urandom_range(0, 2))
        0: begin
          raw = '0;
        end
        1: begin
          raw = '1;
        end
        default: begin
          raw = 64'd1 << (span - 1);
        end
      endcase
    end
    return IN_WIDTH'(raw);
  endfunction

  // Offers one value and returns at the edge that accepts the transaction.
  // The push line is only lowered when a gap is drawn, so a following item
  // with no gap keeps push high without a second assignment in the step.
  task automatic offer_value(input logic [IN_WIDTH-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (full);
  endtask

  // Waits until every queued digit has been read back, lets the block
  // settle, then writes the base. Sampling at the falling edge keeps the
  // idle check clear of the checker's update at the rising edge.
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    radix_we_i <= 1'b1;
    radix_i    <= r;
    @(posedge clk_i);
    radix_we_i <= 1'b0;
  endtask

  // Receiver: one drawn wait per transaction, plus the single long hold.
  // The hold is counted here, independent of the sender, which keeps
  // offering values until the block reports full.
  initial begin : read_digits
    int wait_cycles;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 3);
      if (hold_output && !hold_served) begin
        wait_cycles = LONG_HOLD;
        hold_served = 1'b1;
      end
      if (wait_cycles != 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    logic [RADIX_W-1:0] sweep [RANDOM_PHASES];
    logic [RADIX_W-1:0] base;
    // Out-of-range writes (1, 17, 31) come first so that clamping is hit
    // early; two entries are replaced by random writes below.
    sweep = '{5'd1, 5'd17, 5'd31, 5'd3, 5'd16, 5'd2, 5'd12, 5'd10, 5'd7, 5'd13};

    rst_ni     <= 1'b0;
    push       <= 1'b0;
    value_i    <= '0;
    radix_we_i <= 1'b0;
    radix_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Base 16 straight out of reset: zero, single digits on both sides of
    // the letter boundary, every hex letter, and the widest values.
    offer_value(64'd0);
    offer_value(64'd1);
    offer_value(64'd15);
    offer_value(64'd16);
    offer_value(64'd255);
    offer_value('1);
    offer_value(64'h8000_0000_0000_0000);
    offer_value(64'h0123_4567_89ab_cdef);
    offer_value(64'hfedc_ba98_7654_3210);

    // A write of zero is clamped to base 2; all ones gives the full 64
    // digits, the longest result run of any transaction.
    set_radix(5'd0);
    offer_value(64'd0);
    offer_value(64'd1);
    offer_value(64'd2);
    offer_value('1);
    offer_value(64'h8000_0000_0000_0000);
    offer_value(64'h5555_5555_5555_5555);

    // Decimal: the carry from nine to ten and from 99 to 100, and ten to the nineteenth.
    set_radix(5'd10);
    offer_value(64'd9);
    offer_value(64'd10);
    offer_value(64'd99);
    offer_value(64'd100);
    offer_value(64'd10_000_000_000_000_000_000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      base = sweep[p];
      if (p == 6 || p == 9) begin
        base = RADIX_W'($urandom_range(0, 31));
      end
      set_radix(base);
      no_gaps     = (p % 4 == 3);
      hold_output = (p == 2);
      repeat (PHASE_ITEMS) offer_value(draw_value());
    end
    push <= 1'b0;

    // Let every expected digit arrive, then keep reading a while longer so
    // that any surplus digit is caught by the checker.
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("unsigned_to_text_radix_top test passed");
    end else begin
      $display("unsigned_to_text_radix_top test failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a digit that never comes ends here.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("unsigned_to_text_radix_top test failed");
    $finish;
  end

endmodule
